### hdl/fbpa_pkg.sv
// Shared types, codes and helper functions for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  localparam int SizeW  = 16;
  localparam int CountW = 9;
  localparam int IdxW   = 8;
  localparam int ReqW   = 32;
  localparam int CmdW   = 2;

  // Command codes carried by an input item.
  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_RESET = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [SizeW-1:0]  BLOCK_SIZE_RST  = 16'd64;
  localparam logic [CountW-1:0] BLOCK_COUNT_RST = 9'd256;
  localparam logic [CountW-1:0] FREE_CNT_RST    = 9'd256;
  localparam logic [CountW-1:0] CNT_MAX         = 9'd511;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NULL      = 3'd3,
    ST_NOT_OWNED = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // commit the item and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy; // result register holds an item not yet taken
  } dp_stat_t;

  function automatic logic [CountW-1:0] inc_sat(input logic [CountW-1:0] v);
    inc_sat = (v == CNT_MAX) ? CNT_MAX : v + 9'd1;
  endfunction

  function automatic logic [CountW-1:0] dec_sat(input logic [CountW-1:0] v);
    dec_sat = (v == '0) ? '0 : v - 9'd1;
  endfunction

endpackage

`default_nettype wire

### hdl/fbpa_ctrl.sv
// Controller state machine that sequences one allocator item at a time.
`default_nettype none

module fbpa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fbpa_pkg::dp_stat_t stat_i,
  output fbpa_pkg::dp_cmd_t     cmd_o
);

  fbpa_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpa_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fbpa_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = fbpa_pkg::FSM_EXEC;
      end
      fbpa_pkg::FSM_EXEC: begin
        if (!stat_i.out_busy) state_d = fbpa_pkg::FSM_IDLE;
      end
      default: state_d = fbpa_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      fbpa_pkg::FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      fbpa_pkg::FSM_EXEC: begin
        // Commit only when the result register can take the new item.
        cmd_o.exec = !stat_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/fbpa_dp.sv
// Datapath: link memory, free-list head, fresh-block counter, counts and result register.
`default_nettype none

module fbpa_dp #(
  parameter int NUM_BLOCKS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbpa_pkg::dp_cmd_t             cmd_i,
  output fbpa_pkg::dp_stat_t                 stat_o,
  input  wire logic [fbpa_pkg::SizeW-1:0]    block_size_i,
  input  wire logic [fbpa_pkg::CountW-1:0]   block_count_i,
  input  wire logic [fbpa_pkg::CmdW-1:0]     item_cmd_i,
  input  wire logic [fbpa_pkg::ReqW-1:0]     request_size_i,
  input  wire logic [fbpa_pkg::IdxW-1:0]     block_index_i,
  input  wire logic                          is_null_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         status_o,
  output logic [fbpa_pkg::IdxW-1:0]          granted_index_o,
  output logic [fbpa_pkg::CountW-1:0]        used_count_o,
  output logic [fbpa_pkg::CountW-1:0]        free_count_o
);

  localparam int MemDepth = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int MemAw    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam logic [fbpa_pkg::CountW-1:0] EFF_MAX = 9'(MemDepth);

  // Item registers.
  logic [fbpa_pkg::CmdW-1:0] item_cmd_q;
  logic [fbpa_pkg::ReqW-1:0] item_req_q;
  logic [fbpa_pkg::IdxW-1:0] item_idx_q;
  logic                      item_null_q;

  // Free-list state.
  logic [fbpa_pkg::IdxW-1:0]   head_q, head_d;
  logic                        head_valid_q, head_valid_d;
  logic [fbpa_pkg::CountW-1:0] fresh_q, fresh_d;
  logic [fbpa_pkg::CountW-1:0] used_q, used_d;
  logic [fbpa_pkg::CountW-1:0] free_q, free_d;

  // Result register.
  logic                        out_valid_q;
  fbpa_pkg::status_e           status_q, status_d;
  logic [fbpa_pkg::IdxW-1:0]   granted_q, granted_d;

  // Link memory: each entry holds the next index and whether it continues the list.
  logic [fbpa_pkg::IdxW:0] link_mem [0:MemDepth-1];
  logic [fbpa_pkg::IdxW:0] rd_q;
  logic                    mem_we;

  logic [fbpa_pkg::CountW-1:0] eff_n;
  logic                        free_ok;

  assign eff_n   = (block_count_i > EFF_MAX) ? EFF_MAX : block_count_i;
  assign free_ok = !item_null_q && ({1'b0, item_idx_q} < eff_n);

  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_cmd_q  <= item_cmd_i;
      item_req_q  <= request_size_i;
      item_idx_q  <= block_index_i;
      item_null_q <= is_null_i;
    end
  end

  // The head entry is read every cycle, so the link of the current head is
  // ready by the time the controller commits the next item.
  always_ff @(posedge clk_i) begin
    rd_q <= link_mem[head_q[MemAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[item_idx_q[MemAw-1:0]] <= {head_valid_q, head_q};
    end
  end

  always_comb begin
    head_d       = head_q;
    head_valid_d = head_valid_q;
    fresh_d      = fresh_q;
    used_d       = used_q;
    free_d       = free_q;
    status_d     = fbpa_pkg::ST_OK;
    granted_d    = '0;
    mem_we       = 1'b0;
    case (item_cmd_q)
      fbpa_pkg::CMD_ALLOC: begin
        if (item_req_q > {16'd0, block_size_i}) begin
          status_d = fbpa_pkg::ST_TOO_LARGE;
        end else if (head_valid_q && ({1'b0, head_q} < EFF_MAX)) begin
          granted_d    = head_q;
          head_valid_d = rd_q[fbpa_pkg::IdxW];
          head_d       = rd_q[fbpa_pkg::IdxW-1:0];
          used_d       = fbpa_pkg::inc_sat(used_q);
          free_d       = fbpa_pkg::dec_sat(free_q);
        end else if (fresh_q < eff_n) begin
          granted_d = fresh_q[fbpa_pkg::IdxW-1:0];
          fresh_d   = fresh_q + 9'd1;
          used_d    = fbpa_pkg::inc_sat(used_q);
          free_d    = fbpa_pkg::dec_sat(free_q);
        end else begin
          status_d = fbpa_pkg::ST_EMPTY;
        end
      end
      fbpa_pkg::CMD_FREE: begin
        if (item_null_q) begin
          status_d = fbpa_pkg::ST_NULL;
        end else if (!free_ok) begin
          status_d = fbpa_pkg::ST_NOT_OWNED;
        end else begin
          mem_we       = cmd_i.exec;
          head_d       = item_idx_q;
          head_valid_d = 1'b1;
          used_d       = fbpa_pkg::dec_sat(used_q);
          free_d       = fbpa_pkg::inc_sat(free_q);
        end
      end
      fbpa_pkg::CMD_RESET: begin
        head_d       = '0;
        head_valid_d = 1'b0;
        fresh_d      = '0;
        used_d       = '0;
        free_d       = eff_n;
      end
      default: begin
        status_d = fbpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      head_valid_q <= 1'b0;
      fresh_q      <= '0;
      used_q       <= '0;
      free_q       <= fbpa_pkg::FREE_CNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q       <= head_d;
        head_valid_q <= head_valid_d;
        fresh_q      <= fresh_d;
        used_q       <= used_d;
        free_q       <= free_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign used_count_o    = used_q;
  assign free_count_o    = free_q;

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && !out_ready_i))
    else $error("item committed while the result register was still full");

  a_exec_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("committed item did not show up in the result register");

  a_no_capture_during_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.capture && cmd_i.exec))
    else $error("item captured in the same cycle as a commit");

  a_push_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_cmd_q == fbpa_pkg::CMD_FREE && free_ok)
      |=> (head_valid_q && head_q == $past(item_idx_q)))
    else $error("freed block did not become the list head");

  a_fresh_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= EFF_MAX)
    else $error("fresh-block counter ran past the pool size");

endmodule

`default_nettype wire

### hdl/fixed_block_pool_allocator.sv
// Top level: configuration registers, controller and datapath of the block pool allocator.
// An accepted item is latched in the item registers, then committed to the result register
// once that register is free; a new item is taken only after the commit. The link of the
// list head comes from a registered read of the link memory, in the cycle after acceptance.
// Reset presets the controller, list head, fresh counter, counts and config regs at once.
// The link memory is not cleared; entries are written by a free before a pop reads them.
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Item input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [fbpa_pkg::CmdW-1:0]    cmd_i,
  input  wire logic [fbpa_pkg::ReqW-1:0]    request_size_i,
  input  wire logic [fbpa_pkg::IdxW-1:0]    block_index_i,
  input  wire logic                         is_null_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [2:0]                        status_o,
  output logic [fbpa_pkg::IdxW-1:0]         granted_index_o,
  output logic [fbpa_pkg::CountW-1:0]       used_count_o,
  output logic [fbpa_pkg::CountW-1:0]       free_count_o,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [fbpa_pkg::SizeW-1:0]  block_size_q;
  logic [fbpa_pkg::CountW-1:0] block_count_q;
  logic                        cfg_we;
  logic                        reg_sel;

  fbpa_pkg::dp_cmd_t  dp_cmd;
  fbpa_pkg::dp_stat_t dp_stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= fbpa_pkg::BLOCK_SIZE_RST;
      block_count_q <= fbpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      if (reg_sel == fbpa_pkg::REG_BLOCK_SIZE) begin
        block_size_q <= pwdata[fbpa_pkg::SizeW-1:0];
      end else begin
        block_count_q <= pwdata[fbpa_pkg::CountW-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == fbpa_pkg::REG_BLOCK_SIZE) begin
      prdata = {16'd0, block_size_q};
    end else begin
      prdata = {23'd0, block_count_q};
    end
  end

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  fbpa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .block_size_i    (block_size_q),
    .block_count_i   (block_count_q),
    .item_cmd_i      (cmd_i),
    .request_size_i  (request_size_i),
    .block_index_i   (block_index_i),
    .is_null_i       (is_null_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .used_count_o    (used_count_o),
    .free_count_o    (free_count_o)
  );

endmodule

`default_nettype wire

### tb/fbpa_pool_checker.sv
// Checker for the block pool allocator: tracks the free list, predicts each reply and compares.
`timescale 1ns / 1ps

module fbpa_pool_checker #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [fbpa_pkg::CmdW-1:0]   cmd_i,
  input  logic [fbpa_pkg::ReqW-1:0]   request_size_i,
  input  logic [fbpa_pkg::IdxW-1:0]   block_index_i,
  input  logic                        is_null_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [2:0]                  status_i,
  input  logic [fbpa_pkg::IdxW-1:0]   granted_index_i,
  input  logic [fbpa_pkg::CountW-1:0] used_count_i,
  input  logic [fbpa_pkg::CountW-1:0] free_count_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    fbpa_pkg::status_e           status;
    logic [fbpa_pkg::IdxW-1:0]   granted;
    logic [fbpa_pkg::CountW-1:0] used;
    logic [fbpa_pkg::CountW-1:0] free;
  } pool_reply_t;

  pool_reply_t                 pool_reply_q[$];
  int                          fails;

  logic [fbpa_pkg::SizeW-1:0]  cfg_size;
  logic [fbpa_pkg::CountW-1:0] cfg_count;

  // Free list shadow: a link per block plus a flag that marks the list tail.
  logic [fbpa_pkg::IdxW-1:0]   link_mem[NUM_BLOCKS];
  logic                        link_live[NUM_BLOCKS];
  logic [fbpa_pkg::IdxW-1:0]   head_idx;
  logic                        head_ok;
  logic [fbpa_pkg::CountW-1:0] fresh_idx;
  logic [fbpa_pkg::CountW-1:0] used_cnt;
  logic [fbpa_pkg::CountW-1:0] free_cnt;

  function automatic logic [fbpa_pkg::CountW-1:0] live_blocks();
    logic [fbpa_pkg::CountW-1:0] n;
    n = cfg_count;
    if (int'(n) > NUM_BLOCKS) n = fbpa_pkg::CountW'(NUM_BLOCKS);
    if (n > 9'd256) n = 9'd256;
    return n;
  endfunction

  function automatic logic [fbpa_pkg::CountW-1:0] bump_up(
    input logic [fbpa_pkg::CountW-1:0] v);
    return (v == fbpa_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [fbpa_pkg::CountW-1:0] bump_down(
    input logic [fbpa_pkg::CountW-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Applies one item to the shadow pool and returns the reply it should produce.
  function automatic pool_reply_t pool_step(input logic [fbpa_pkg::CmdW-1:0] c,
                                            input logic [fbpa_pkg::ReqW-1:0] req,
                                            input logic [fbpa_pkg::IdxW-1:0] idx,
                                            input logic nul);
    pool_reply_t                 r;
    logic [fbpa_pkg::CountW-1:0] n;
    n         = live_blocks();
    r.status  = fbpa_pkg::ST_OK;
    r.granted = '0;
    case (c)
      fbpa_pkg::CMD_ALLOC: begin
        if (req > {16'd0, cfg_size}) begin
          r.status = fbpa_pkg::ST_TOO_LARGE;
        end else if (head_ok && int'(head_idx) < NUM_BLOCKS) begin
          r.granted = head_idx;
          head_ok   = link_live[r.granted];
          head_idx  = link_mem[r.granted];
          used_cnt  = bump_up(used_cnt);
          free_cnt  = bump_down(free_cnt);
        end else if (fresh_idx < n) begin
          r.granted = fresh_idx[fbpa_pkg::IdxW-1:0];
          fresh_idx = fresh_idx + 1'b1;
          used_cnt  = bump_up(used_cnt);
          free_cnt  = bump_down(free_cnt);
        end else begin
          r.status = fbpa_pkg::ST_EMPTY;
        end
      end
      fbpa_pkg::CMD_FREE: begin
        if (nul) begin
          r.status = fbpa_pkg::ST_NULL;
        end else if ({1'b0, idx} >= n) begin
          r.status = fbpa_pkg::ST_NOT_OWNED;
        end else begin
          link_mem[idx]  = head_idx;
          link_live[idx] = head_ok;
          head_idx       = idx;
          head_ok        = 1'b1;
          used_cnt       = bump_down(used_cnt);
          free_cnt       = bump_up(free_cnt);
        end
      end
      fbpa_pkg::CMD_RESET: begin
        head_idx  = '0;
        head_ok   = 1'b0;
        fresh_idx = '0;
        used_cnt  = '0;
        free_cnt  = n;
      end
      default: ;
    endcase
    r.used = used_cnt;
    r.free = free_cnt;
    return r;
  endfunction

  task automatic log_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t want;
    pool_reply_t got;
    logic [31:0] reg_val;
    if (!rst_ni) begin
      pool_reply_q.delete();
      fails     = 0;
      cfg_size  = fbpa_pkg::BLOCK_SIZE_RST;
      cfg_count = fbpa_pkg::BLOCK_COUNT_RST;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        link_mem[i]  = '0;
        link_live[i] = 1'b0;
      end
      head_idx     = '0;
      head_ok      = 1'b0;
      fresh_idx    = '0;
      used_cnt     = '0;
      free_cnt     = fbpa_pkg::FREE_CNT_RST;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == fbpa_pkg::REG_BLOCK_SIZE) cfg_size = pwdata[fbpa_pkg::SizeW-1:0];
          else cfg_count = pwdata[fbpa_pkg::CountW-1:0];
        end else begin
          reg_val = (paddr[2] == fbpa_pkg::REG_BLOCK_SIZE) ? 32'(cfg_size) : 32'(cfg_count);
          if (prdata !== reg_val)
            log_fail($sformatf("register read at %0d: expected %0d, got %0d",
                               paddr, reg_val, prdata));
        end
      end

      // Replies are retired before new items are queued, so a reply can never
      // match an item accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        got.status  = fbpa_pkg::status_e'(status_i);
        got.granted = granted_index_i;
        got.used    = used_count_i;
        got.free    = free_count_i;
        if (pool_reply_q.size() == 0) begin
          log_fail($sformatf({"reply with nothing outstanding:",
                              " status %0d index %0d used %0d free %0d"},
                             status_i, granted_index_i, used_count_i, free_count_i));
        end else begin
          want = pool_reply_q.pop_front();
          if (got !== want)
            log_fail($sformatf({"reply mismatch: expected status %0d index %0d used %0d free %0d,",
                                " got status %0d index %0d used %0d free %0d"},
                               want.status, want.granted, want.used, want.free,
                               status_i, granted_index_i, used_count_i, free_count_i));
        end
      end

      if (in_valid_i && in_ready_i)
        pool_reply_q.push_back(pool_step(cmd_i, request_size_i, block_index_i, is_null_i));

      pending_o    <= pool_reply_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/tb_fixed_block_pool_allocator.sv
// Testbench top for the block pool allocator: clock, reset, item and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

  localparam logic [fbpa_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] SIZE_ADDR  = {fbpa_pkg::REG_BLOCK_SIZE, 2'b00};
  localparam logic [2:0] COUNT_ADDR = {fbpa_pkg::REG_BLOCK_COUNT, 2'b00};

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [fbpa_pkg::CmdW-1:0]   cmd = fbpa_pkg::CMD_ALLOC;
  logic [fbpa_pkg::ReqW-1:0]   request_size = '0;
  logic [fbpa_pkg::IdxW-1:0]   block_index = '0;
  logic                        is_null = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [2:0]                  status;
  logic [fbpa_pkg::IdxW-1:0]   granted_index;
  logic [fbpa_pkg::CountW-1:0] used_count;
  logic [fbpa_pkg::CountW-1:0] free_count;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  int fail_count;
  int pending;
  int cur_size  = 64;
  int cur_count = 256;
  bit steady    = 1'b0;

  fixed_block_pool_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .request_size_i  (request_size),
    .block_index_i   (block_index),
    .is_null_i       (is_null),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .granted_index_o (granted_index),
    .used_count_o    (used_count),
    .free_count_o    (free_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  fbpa_pool_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .cmd_i           (cmd),
    .request_size_i  (request_size),
    .block_index_i   (block_index),
    .is_null_i       (is_null),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .granted_index_i (granted_index),
    .used_count_i    (used_count),
    .free_count_i    (free_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("Verification failed");
    $finish;
  end

  // The reply side stalls about six percent of the time, except in steady stretches.
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 6);
  end

  task automatic pause_input();
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic [fbpa_pkg::CmdW-1:0] c,
                           input logic [fbpa_pkg::ReqW-1:0] req,
                           input logic [fbpa_pkg::IdxW-1:0] idx, input logic nul);
    in_valid     <= 1'b1;
    cmd          <= c;
    request_size <= req;
    block_index  <= idx;
    is_null      <= nul;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pause_input();
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_pool();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Registers change only while nothing is in flight; upper data bits carry noise.
  task automatic set_pool(input int size, input int count);
    drain_pool();
    apb_xfer(1'b1, SIZE_ADDR, {16'($urandom_range(16'hFFFF)), size[15:0]});
    apb_xfer(1'b1, COUNT_ADDR, {23'($urandom_range(23'h7FFFFF)), count[8:0]});
    apb_xfer(1'b0, SIZE_ADDR, '0);
    apb_xfer(1'b0, COUNT_ADDR, '0);
    cur_size  = size;
    cur_count = count;
  endtask

  task automatic send_random_item();
    int          pick;
    int          live;
    logic [31:0] req;
    logic [7:0]  idx;
    pick = $urandom_range(99);
    live = (cur_count > 256) ? 256 : cur_count;
    idx  = 8'($urandom_range(255));
    if (live > 0 && $urandom_range(9) != 0) idx = 8'($urandom_range(live - 1));
    case ($urandom_range(19))
      0:       req = $urandom();
      1:       req = cur_size + 1;
      2:       req = cur_size;
      default: req = $urandom_range(cur_size);
    endcase
    if (pick < 48) send_item(fbpa_pkg::CMD_ALLOC, req, idx, 1'($urandom_range(1)));
    else if (pick < 86) send_item(fbpa_pkg::CMD_FREE, req, idx, 1'b0);
    else if (pick < 91) send_item(fbpa_pkg::CMD_FREE, req, idx, 1'b1);
    else if (pick < 96) send_item(CMD_UNUSED, $urandom(), 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
    else send_item(fbpa_pkg::CMD_RESET, $urandom(), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
  endtask

  initial begin
    int sizes[7];
    int counts[7];
    sizes  = '{65535, 8, 16, 40, 65535, 0, 1000};
    counts = '{256, 1, 0, 7, 511, 3, 33};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers, then the basic paths at the default setting.
    apb_xfer(1'b0, SIZE_ADDR, '0);
    apb_xfer(1'b0, COUNT_ADDR, '0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd0, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd64, 8'd255, 1'b1);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd65, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 8'd0, 1'b0);
    // A null pointer is ignored even when its index names a real block.
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd0, 1'b1);
    send_item(fbpa_pkg::CMD_FREE, 32'hFFFF_FFFF, 8'd255, 1'b1);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd1, 1'b0);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd1, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd32, 8'd0, 1'b0);
    send_item(CMD_UNUSED, 32'hA5A5_5A5A, 8'hAA, 1'b1);
    send_item(fbpa_pkg::CMD_RESET, 32'd0, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd7, 8'd0, 1'b0);

    // Shrinking the pool without a relink: out-of-range frees, exhaustion, double free.
    set_pool(8, 2);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd2, 1'b0);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd255, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd8, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd9, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd0, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd1, 1'b0);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd1, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd3, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_ALLOC, 32'd4, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_RESET, 32'd0, 8'd0, 1'b0);
    send_item(fbpa_pkg::CMD_FREE, 32'd0, 8'd0, 1'b0);

    for (int p = 0; p < 7; p++) begin
      set_pool(sizes[p], counts[p]);
      if ($urandom_range(3) != 0)
        send_item(fbpa_pkg::CMD_RESET, $urandom(), 8'($urandom_range(255)), 1'b0);
      repeat (10) send_random_item();
    end

    // Drive the used count into saturation: drain the pool, then loop on a
    // block that was freed twice and so links to itself.
    set_pool(64, 256);
    send_item(fbpa_pkg::CMD_RESET, 32'd0, 8'd0, 1'b0);
    steady = 1'b1;
    repeat (256) send_item(fbpa_pkg::CMD_ALLOC, $urandom_range(64), 8'($urandom_range(255)),
                           1'b0);
    begin
      logic [7:0] twice;
      twice = 8'($urandom_range(255));
      send_item(fbpa_pkg::CMD_FREE, $urandom(), twice, 1'b0);
      send_item(fbpa_pkg::CMD_FREE, $urandom(), twice, 1'b0);
    end
    repeat (258) send_item(fbpa_pkg::CMD_ALLOC, $urandom_range(64), 8'($urandom_range(255)),
                           1'b0);
    steady = 1'b0;

    // And the free count, by freeing into a full pool.
    send_item(fbpa_pkg::CMD_RESET, 32'd0, 8'd0, 1'b0);
    repeat (256) send_item(fbpa_pkg::CMD_FREE, $urandom(), 8'($urandom_range(255)), 1'b0);

    drain_pool();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
